/* src/tpva_pkg.sv */
// Shared types and constants for the three point vertex angle block.
package tpva_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int NORM_SHIFT = 38;
  localparam int XY_BITS = 42;
  localparam int Z_BITS = 32;
  localparam int ANGLE_BITS = 15;
  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 15'd18000;
  localparam logic signed [Z_BITS-1:0] QUARTER_Q16 = 32'sd589824000;

  typedef logic signed [XY_BITS-1:0] xy_t;
  typedef logic signed [Z_BITS-1:0] zang_t;

  function automatic zang_t atan_q16(input logic [4:0] i);
    zang_t r;
    begin
      case (i)
        5'd0: r = 32'sd294912000;
        5'd1: r = 32'sd174096720;
        5'd2: r = 32'sd91987925;
        5'd3: r = 32'sd46694507;
        5'd4: r = 32'sd23437865;
        5'd5: r = 32'sd11730358;
        5'd6: r = 32'sd5866611;
        5'd7: r = 32'sd2933484;
        5'd8: r = 32'sd1466765;
        5'd9: r = 32'sd733385;
        5'd10: r = 32'sd366693;
        5'd11: r = 32'sd183347;
        5'd12: r = 32'sd91673;
        5'd13: r = 32'sd45837;
        5'd14: r = 32'sd22918;
        5'd15: r = 32'sd11459;
        5'd16: r = 32'sd5730;
        5'd17: r = 32'sd2865;
        5'd18: r = 32'sd1432;
        5'd19: r = 32'sd716;
        5'd20: r = 32'sd358;
        5'd21: r = 32'sd179;
        5'd22: r = 32'sd90;
        5'd23: r = 32'sd45;
        5'd24: r = 32'sd22;
        5'd25: r = 32'sd11;
        5'd26: r = 32'sd6;
        5'd27: r = 32'sd3;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Classified item passed from front to back.
  typedef struct packed {
    logic degen;
    logic [XY_BITS-1:0] x;
    logic [XY_BITS-1:0] y;
    zang_t z;
  } work_t;

endpackage

/* src/tpva_front.sv */
// Front part: differences, products, quadrant fold and normalization.
module tpva_front #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [COORD_BITS-1:0] hx, hy, kx, ky, ax, ay,
  output logic out_valid,
  input  logic out_stall,
  output tpva_pkg::work_t out_item
);
  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * DB + 2;
  localparam int XB = tpva_pkg::XY_BITS;
  localparam int SB = $clog2(XB);

  logic s1_v, s2_v, s3_v;
  logic adv;
  assign adv = !(s3_v && out_stall);
  assign in_stall = !adv;

  // stage 1: differences
  logic signed [DB-1:0] ux, uy, vx, vy;
  logic s1_deg;
  // stage 2: products
  logic signed [PB-1:0] dot, crs;
  logic s2_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  logic signed [PB-1:0] cr_raw;
  logic [XB-1:0] fx, fy, mx;
  logic [SB-1:0] sh;
  tpva_pkg::zang_t fz;

  assign cr_raw = PB'(ux) * PB'(vy) - PB'(uy) * PB'(vx);

  always_comb begin
    if (!dot[PB-1]) begin
      fx = XB'(dot);
      fy = XB'(crs);
      fz = '0;
    end else begin
      fx = XB'(crs);
      fy = XB'(-dot);
      fz = tpva_pkg::QUARTER_Q16;
    end
    mx = fx | fy;
    sh = '0;
    for (int b = 0; b < tpva_pkg::NORM_SHIFT; b++) begin
      if (mx[b]) sh = SB'(tpva_pkg::NORM_SHIFT - b);
    end
    if (mx == '0) sh = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux <= DB'($signed({1'b0, hx})) - DB'($signed({1'b0, kx}));
      uy <= DB'($signed({1'b0, hy})) - DB'($signed({1'b0, ky}));
      vx <= DB'($signed({1'b0, ax})) - DB'($signed({1'b0, kx}));
      vy <= DB'($signed({1'b0, ay})) - DB'($signed({1'b0, ky}));
      s1_deg <= (hx == kx && hy == ky) || (ax == kx && ay == ky);
      dot <= PB'(ux) * PB'(vx) + PB'(uy) * PB'(vy);
      crs <= cr_raw[PB-1] ? -cr_raw : cr_raw;
      s2_deg <= s1_deg;
      out_item.degen <= s2_deg;
      out_item.x <= fx << sh;
      out_item.y <= fy << sh;
      out_item.z <= fz;
    end
  end

  assign out_valid = s3_v;
endmodule

/* src/tpva_fifo.sv */
// Short queue between the front and back parts.
module tpva_fifo (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tpva_pkg::work_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output tpva_pkg::work_t out_item
);
  tpva_pkg::work_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;

  assign in_stall = cnt[2];
  assign out_valid = cnt != 3'd0;
  assign wr = in_valid && !in_stall;
  assign rd = out_valid && !out_stall;
  assign out_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_item;
  end
endmodule

/* src/tpva_back.sv */
// Back part: pipelined vectoring CORDIC and result rounding.
module tpva_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tpva_pkg::work_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output logic [tpva_pkg::ANGLE_BITS-1:0] angle,
  output logic degen
);
  localparam int N = tpva_pkg::CORDIC_STEPS;
  localparam int ZB = tpva_pkg::Z_BITS;

  tpva_pkg::xy_t x [N+1];
  tpva_pkg::xy_t y [N+1];
  tpva_pkg::zang_t z [N+1];
  logic [N:0] v, d;
  logic adv;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign x[0] = tpva_pkg::xy_t'(in_item.x);
  assign y[0] = tpva_pkg::xy_t'(in_item.y);
  assign z[0] = in_item.z;
  assign v[0] = in_valid;
  assign d[0] = in_item.degen;

  for (genvar i = 0; i < N; i++) begin : g_step
    tpva_pkg::xy_t xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d[i+1] <= d[i];
        if (!y[i][tpva_pkg::XY_BITS-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + tpva_pkg::atan_q16(5'(i));
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - tpva_pkg::atan_q16(5'(i));
        end
      end
    end
  end

  logic signed [ZB-1:0] zr, r;
  assign zr = z[N] + ZB'(32768);
  assign r = zr >>> 16;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v[N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degen <= d[N];
      if (d[N] || r[ZB-1]) angle <= '0;
      else if (r > ZB'(tpva_pkg::ANGLE_MAX)) angle <= tpva_pkg::ANGLE_MAX;
      else angle <= r[tpva_pkg::ANGLE_BITS-1:0];
    end
  end
endmodule

/* src/three_point_vertex_angle.sv */
// Top level of the three point vertex angle block.
// Takes one point triple per clock while in_stall is low and returns the
// vertex angle in 0.01 degree, with degenerate set when the vertex equals an
// end point. A three-stage front computes dot and cross products and
// normalizes; a four-entry queue feeds a 28-stage CORDIC back end with one
// output register. An item passes through the three front stages, one queue
// write, the 28 CORDIC stages and then the output register; throughput is one
// item per cycle while out_stall stays low.
module three_point_vertex_angle #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [COORD_BITS-1:0] hip_x,
  input  logic [COORD_BITS-1:0] hip_y,
  input  logic [COORD_BITS-1:0] knee_x,
  input  logic [COORD_BITS-1:0] knee_y,
  input  logic [COORD_BITS-1:0] ankle_x,
  input  logic [COORD_BITS-1:0] ankle_y,
  output logic out_valid,
  input  logic out_stall,
  output logic [tpva_pkg::ANGLE_BITS-1:0] angle_centideg,
  output logic degenerate
);
  tpva_pkg::work_t f_item, q_item;
  logic f_v, f_s, q_v, q_s;

  tpva_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .hx(hip_x), .hy(hip_y), .kx(knee_x), .ky(knee_y), .ax(ankle_x), .ay(ankle_y),
    .out_valid(f_v), .out_stall(f_s), .out_item(f_item)
  );

  tpva_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(f_v), .in_stall(f_s), .in_item(f_item),
    .out_valid(q_v), .out_stall(q_s), .out_item(q_item)
  );

  tpva_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_v), .in_stall(q_s), .in_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle(angle_centideg), .degen(degenerate)
  );
endmodule
